[rtl/rrs_pkg.sv]
// Shared types and constants for the range replace stream block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rrs_pkg;

   localparam int SPAN_DEPTH        = 64;
   localparam int SPAN_IDX_W        = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;
   localparam int SPAN_CNT_W        = $clog2(SPAN_DEPTH + 1);
   localparam int MAX_REPLACE_BYTES = 8;
   localparam int BYTE_IDX_W        = (MAX_REPLACE_BYTES > 1) ? $clog2(MAX_REPLACE_BYTES) : 1;
   localparam int REPL_LEN_W        = 4;
   localparam int CHAR_W            = 8;
   localparam int REPL_TEXT_W       = 64;
   localparam int POS_W             = 32;
   localparam int BUDGET_W          = 2;
   localparam int INSERT_BUDGET     = 2;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_REPL_TEXT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPL_LEN  = 1'd1;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_CHAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0] span_hi;
      logic [POS_W-1:0] span_lo;
   } span_type;

endpackage

[rtl/rrs_req_if.sv]
// Request channel: span pushes and text characters, valid/ready handshake.
// Depends on rrs_pkg.
`timescale 1ns / 1ps

interface rrs_req_if import rrs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [POS_W-1:0]  range_begin;
   logic [POS_W-1:0]  range_end;
   logic [CHAR_W-1:0] text_char;
   logic              text_last;

   modport source (output valid, req_type, range_begin, range_end, text_char, text_last,
                   input ready);
   modport sink   (input valid, req_type, range_begin, range_end, text_char, text_last,
                   output ready);
endinterface

[rtl/rrs_rsp_if.sv]
// Response channel: output characters with framing flags, valid/ready handshake.
// Depends on rrs_pkg.
`timescale 1ns / 1ps

interface rrs_rsp_if import rrs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              run_last;
   logic              text_end;
   logic              overflow;

   modport source (output valid, out_char, run_last, text_end, overflow, input ready);
   modport sink   (input valid, out_char, run_last, text_end, overflow, output ready);
endinterface

[rtl/range_replace_stream.sv]
// Top level of the range replace stream block: span queue, scan sequencer, output stages.
// Depends on rrs_pkg, rrs_req_if and rrs_rsp_if.
//
// Usage: before a text, send push transactions (req_type 0) carrying sorted [begin,end)
// spans; they fill a 64-entry span memory. Then send text characters (req_type 1), the
// final one with text_last set. Characters outside every span come out unchanged; where
// a span begins, the replacement bytes from the csr registers come out and the characters
// inside the span are dropped. Each rsp transaction carries run_last on the last byte of
// its request and text_end on the last byte of the text.
// Flow: the next request is accepted as the current one completes. A character at a span
// start waits while that span's replacement bytes are emitted; retiring a span past its
// end and closing the final character are further sequencer steps.
// The span memory has one read port, so the sequencer looks at one span per cycle.
// Path: item register, hold stage, output register. A byte followed by more bytes of
// the same request waits in the hold stage until the next one.
// Reset: synchronous, clears the span queue, text position, overflow flag and the
// replacement registers; span memory contents are not cleared and need no clearing pass.
// Stall: when rsp.ready is low the output and hold stages fill and req.ready drops
// as soon as the sequencer needs to emit another byte.
`timescale 1ns / 1ps

module range_replace_stream import rrs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   rrs_req_if.sink                req,
   rrs_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   span_type              span_mem [SPAN_DEPTH];
   span_type              span_rd_ff;
   logic                  mem_we;
   logic [SPAN_IDX_W-1:0] mem_waddr;
   logic [SPAN_IDX_W-1:0] mem_raddr;
   span_type              mem_wdata;

   logic [REPL_TEXT_W-1:0] repl_text_ff, repl_text_in;
   logic [REPL_LEN_W-1:0]  repl_len_ff, repl_len_in;

   state_type              state_ff, state_in;
   logic                   item_type_ff;
   logic [POS_W-1:0]       item_lo_ff, item_hi_ff;
   logic [CHAR_W-1:0]      item_char_ff;
   logic                   item_last_ff;
   logic [BUDGET_W-1:0]    budget_ff, budget_in;
   logic                   ins_done_ff, ins_done_in;
   logic [BYTE_IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic                   ret_tail_ff, ret_tail_in;
   logic [SPAN_CNT_W-1:0]  span_count_ff, span_count_in;
   logic [SPAN_CNT_W-1:0]  span_index_ff, span_index_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   ovf_ff, ovf_in;

   logic                   pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0]      pend_char_ff, pend_char_in;
   logic                   pend_ovf_ff, pend_ovf_in;
   logic                   pend_last_ff, pend_last_in;
   logic                   pend_end_ff, pend_end_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_end_ff, rsp_end_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   head_valid;
   logic [POS_W-1:0]       pos_next;
   logic [REPL_LEN_W-1:0]  len_eff;
   logic                   last_byte;
   logic                   out_free;
   logic                   can_byte;
   logic                   produce;
   logic [CHAR_W-1:0]      prod_char;
   logic                   step_done;
   logic                   end_text;
   logic                   accept;
   logic                   pend_move;
   logic                   pend_close;

   assign head_valid = span_index_ff < span_count_ff;
   assign pos_next   = pos_ff + 1'b1;
   assign len_eff    = (repl_len_ff > REPL_LEN_W'(MAX_REPLACE_BYTES)) ?
                       REPL_LEN_W'(MAX_REPLACE_BYTES) : repl_len_ff;
   assign last_byte  = REPL_LEN_W'(byte_idx_ff) == (len_eff - 1'b1);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign can_byte   = !pend_valid_ff || out_free;

   // configuration registers
   always_comb begin
      repl_text_in = repl_text_ff;
      repl_len_in  = repl_len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REPL_TEXT: repl_text_in = csr_wdata[REPL_TEXT_W-1:0];
            CSR_REPL_LEN:  repl_len_in  = csr_wdata[REPL_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // scan sequencer
   always_comb begin
      state_in      = state_ff;
      budget_in     = budget_ff;
      ins_done_in   = ins_done_ff;
      byte_idx_in   = byte_idx_ff;
      ret_tail_in   = ret_tail_ff;
      span_count_in = span_count_ff;
      span_index_in = span_index_ff;
      pos_in        = pos_ff;
      ovf_in        = ovf_ff;
      mem_we        = 1'b0;
      mem_waddr     = span_count_ff[SPAN_IDX_W-1:0];
      mem_wdata     = '{span_hi: item_hi_ff, span_lo: item_lo_ff};
      produce       = 1'b0;
      prod_char     = item_char_ff;
      step_done     = 1'b0;
      end_text      = 1'b0;

      case (state_ff)
         ST_IDLE: ;
         ST_SCAN: begin
            if (item_type_ff == REQ_PUSH) begin
               if (span_count_ff < SPAN_CNT_W'(SPAN_DEPTH)) begin
                  mem_we        = 1'b1;
                  span_count_in = span_count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               step_done = 1'b1;
            end else if (!head_valid || span_rd_ff.span_lo > pos_ff) begin
               if (can_byte) begin
                  produce = 1'b1;
                  if (item_last_ff) begin
                     state_in = ST_TAIL;
                  end else begin
                     step_done = 1'b1;
                  end
               end
            end else if (span_rd_ff.span_lo == pos_ff && !ins_done_ff && budget_ff != '0) begin
               budget_in   = budget_ff - 1'b1;
               ins_done_in = 1'b1;
               if (len_eff != '0) begin
                  state_in    = ST_INSERT;
                  byte_idx_in = '0;
                  ret_tail_in = 1'b0;
               end
            end else if (span_rd_ff.span_hi > pos_ff) begin
               if (item_last_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  step_done = 1'b1;
               end
            end else begin
               span_index_in = span_index_ff + 1'b1;
               ins_done_in   = 1'b0;
            end
         end
         ST_INSERT: begin
            prod_char = repl_text_ff[CHAR_W*byte_idx_ff +: CHAR_W];
            if (can_byte) begin
               produce = 1'b1;
               if (last_byte) begin
                  state_in = ret_tail_ff ? ST_TAIL : ST_SCAN;
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (head_valid && span_rd_ff.span_lo == pos_next) begin
               if (!ins_done_ff && budget_ff != '0) begin
                  budget_in   = budget_ff - 1'b1;
                  ins_done_in = 1'b1;
                  if (len_eff != '0) begin
                     state_in    = ST_INSERT;
                     byte_idx_in = '0;
                     ret_tail_in = 1'b1;
                  end
               end else begin
                  span_index_in = span_index_ff + 1'b1;
                  ins_done_in   = 1'b0;
               end
            end else begin
               step_done = 1'b1;
               end_text  = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (step_done && item_type_ff == REQ_CHAR) begin
         if (end_text) begin
            span_count_in = '0;
            span_index_in = '0;
            pos_in        = '0;
            ovf_in        = 1'b0;
         end else begin
            pos_in = pos_next;
         end
      end

      req.ready = (state_ff == ST_IDLE) || step_done;
      accept    = req.valid && req.ready;
      if (accept) begin
         state_in    = ST_SCAN;
         budget_in   = BUDGET_W'(INSERT_BUDGET);
         ins_done_in = 1'b0;
      end else if (step_done) begin
         state_in = ST_IDLE;
      end
      mem_raddr = span_index_in[SPAN_IDX_W-1:0];
   end

   // hold stage and output register
   always_comb begin
      pend_move  = pend_valid_ff && out_free && (pend_last_ff || produce);
      pend_close = step_done && !produce && pend_valid_ff && !pend_last_ff;

      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_ovf_in   = pend_ovf_ff;
      pend_last_in  = pend_last_ff;
      pend_end_in   = pend_end_ff;
      if (produce) begin
         pend_valid_in = 1'b1;
         pend_char_in  = prod_char;
         pend_ovf_in   = ovf_ff;
         pend_last_in  = step_done;
         pend_end_in   = step_done && end_text;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end else if (pend_close) begin
         pend_last_in = 1'b1;
         pend_end_in  = end_text;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = pend_char_ff;
         rsp_last_in  = pend_last_ff;
         rsp_end_in   = pend_end_ff;
         rsp_ovf_in   = pend_ovf_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         span_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_we && mem_waddr == mem_raddr) begin
         span_rd_ff <= mem_wdata;
      end else begin
         span_rd_ff <= span_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_text_ff  <= '0;
         repl_len_ff   <= '0;
         state_ff      <= ST_IDLE;
         budget_ff     <= '0;
         ins_done_ff   <= 1'b0;
         byte_idx_ff   <= '0;
         ret_tail_ff   <= 1'b0;
         span_count_ff <= '0;
         span_index_ff <= '0;
         pos_ff        <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         repl_text_ff  <= repl_text_in;
         repl_len_ff   <= repl_len_in;
         state_ff      <= state_in;
         budget_ff     <= budget_in;
         ins_done_ff   <= ins_done_in;
         byte_idx_ff   <= byte_idx_in;
         ret_tail_ff   <= ret_tail_in;
         span_count_ff <= span_count_in;
         span_index_ff <= span_index_in;
         pos_ff        <= pos_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         pend_last_ff  <= pend_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_type_ff <= req.req_type;
         item_lo_ff   <= req.range_begin;
         item_hi_ff   <= req.range_end;
         item_char_ff <= req.text_char;
         item_last_ff <= req.text_last;
      end
      pend_char_ff <= pend_char_in;
      pend_ovf_ff  <= pend_ovf_in;
      pend_end_ff  <= pend_end_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = rsp_char_ff;
   assign rsp.run_last = rsp_last_ff;
   assign rsp.text_end = rsp_end_ff;
   assign rsp.overflow = rsp_ovf_ff;

endmodule
